FILE: design/smartcard_atr_parser_defines.svh
// Assertion macros shared by the answer-to-reset parser RTL.
`ifndef SMARTCARD_ATR_PARSER_DEFINES_SVH
`define SMARTCARD_ATR_PARSER_DEFINES_SVH

`ifndef ASSERT_OFF
// Clocked check, masked while reset is high.
`define SCATR_ASSERT(label, clk, rst, prop) \
   label: assert property (@(posedge clk) disable iff (rst) prop) \
      else $error("scatr assertion failed");
// Clocked check that also holds across reset.
`define SCATR_ASSERT_ALWAYS(label, clk, prop) \
   label: assert property (@(posedge clk) prop) \
      else $error("scatr assertion failed");
`else
`define SCATR_ASSERT(label, clk, rst, prop)
`define SCATR_ASSERT_ALWAYS(label, clk, prop)
`endif

`endif

FILE: design/scatr_pkg.sv
// Types, codes and lookup tables of the answer-to-reset parser.
package scatr_pkg;

   // parse phases
   localparam logic [2:0] PH_TS   = 3'd0;
   localparam logic [2:0] PH_T0   = 3'd1;
   localparam logic [2:0] PH_IF   = 3'd2;
   localparam logic [2:0] PH_HIST = 3'd3;
   localparam logic [2:0] PH_TCK  = 3'd4;
   localparam logic [2:0] PH_DONE = 3'd5;

   // field kinds
   localparam logic [3:0] KIND_TS     = 4'd0;
   localparam logic [3:0] KIND_T0     = 4'd1;
   localparam logic [3:0] KIND_TA     = 4'd2;
   localparam logic [3:0] KIND_TB     = 4'd3;
   localparam logic [3:0] KIND_TC     = 4'd4;
   localparam logic [3:0] KIND_TD     = 4'd5;
   localparam logic [3:0] KIND_HIST   = 4'd6;
   localparam logic [3:0] KIND_TCK    = 4'd7;
   localparam logic [3:0] KIND_EXCESS = 4'd8;

   // decode kinds
   localparam logic [4:0] DK_NONE     = 5'd0;
   localparam logic [4:0] DK_CONV     = 5'd1;
   localparam logic [4:0] DK_FORMAT   = 5'd2;
   localparam logic [4:0] DK_RATES    = 5'd3;
   localparam logic [4:0] DK_SPECIFIC = 5'd4;
   localparam logic [4:0] DK_IFSC     = 5'd5;
   localparam logic [4:0] DK_CLASS    = 5'd6;
   localparam logic [4:0] DK_PROG     = 5'd7;
   localparam logic [4:0] DK_NO_VPP   = 5'd8;
   localparam logic [4:0] DK_PI2      = 5'd9;
   localparam logic [4:0] DK_PI2_RFU  = 5'd10;
   localparam logic [4:0] DK_BWI_CWI  = 5'd11;
   localparam logic [4:0] DK_EGT      = 5'd12;
   localparam logic [4:0] DK_WI       = 5'd13;
   localparam logic [4:0] DK_EDC      = 5'd14;
   localparam logic [4:0] DK_TD       = 5'd15;
   localparam logic [4:0] DK_EXCESS   = 5'd16;

   // status codes
   localparam logic [2:0] ST_BUSY      = 3'd0;
   localparam logic [2:0] ST_OK        = 3'd1;
   localparam logic [2:0] ST_BAD_CHECK = 3'd2;
   localparam logic [2:0] ST_TRUNC     = 3'd3;
   localparam logic [2:0] ST_EXCESS    = 3'd4;

   // convention and error code values carried in part_low
   localparam logic [5:0] CONV_DIRECT  = 6'd0;
   localparam logic [5:0] CONV_INVERSE = 6'd1;
   localparam logic [5:0] CONV_UNDEF   = 6'd2;
   localparam logic [5:0] EDC_LRC      = 6'd0;
   localparam logic [5:0] EDC_CRC      = 6'd1;
   localparam logic [5:0] EDC_RFU      = 6'd2;

   localparam logic [7:0] TS_DIRECT    = 8'h3B;
   localparam logic [7:0] TS_INVERSE   = 8'h3F;
   localparam logic [7:0] PI2_LOW      = 8'd50;
   localparam logic [7:0] PI2_HIGH     = 8'd250;
   localparam logic [3:0] GROUP_MAX    = 4'd15;
   localparam logic [3:0] PROTO_T1     = 4'd1;

   typedef struct packed {
      logic [2:0] phase;
      logic [3:0] pending;
      logic [3:0] group;
      logic [3:0] protocol;
      logic [3:0] hist_left;
      logic [7:0] xor_acc;
      logic       check_req;
      logic       excess;
   } state_type;

   localparam state_type STATE_RESET = '{
      phase:     PH_TS,
      pending:   4'd0,
      group:     4'd1,
      protocol:  4'd0,
      hist_left: 4'd0,
      xor_acc:   8'd0,
      check_req: 1'b0,
      excess:    1'b0
   };

   typedef struct packed {
      logic [3:0]  field_kind;
      logic [3:0]  group_index;
      logic [3:0]  protocol_in_effect;
      logic [7:0]  echo_byte;
      logic [4:0]  decode_kind;
      logic [3:0]  part_high;
      logic [5:0]  part_low;
      logic [11:0] clock_rate_factor;
      logic [5:0]  baud_divisor;
      logic [2:0]  status;
   } result_type;

   // next phase once a byte has been consumed
   function automatic logic [2:0] settle_phase(input logic [3:0] pending,
                                               input logic [3:0] hist_left,
                                               input logic       check_req);
      logic [2:0] ph;
      if (pending != 4'd0)
         ph = PH_IF;
      else if (hist_left != 4'd0)
         ph = PH_HIST;
      else if (check_req)
         ph = PH_TCK;
      else
         ph = PH_DONE;
      return ph;
   endfunction

   // clock rate conversion factor Fi, zero for reserved codes
   function automatic logic [11:0] fi_lookup(input logic [3:0] code);
      logic [11:0] fi;
      unique case (code)
         4'd0, 4'd1: fi = 12'd372;
         4'd2:       fi = 12'd558;
         4'd3:       fi = 12'd744;
         4'd4:       fi = 12'd1116;
         4'd5:       fi = 12'd1488;
         4'd6:       fi = 12'd1860;
         4'd9:       fi = 12'd512;
         4'd10:      fi = 12'd768;
         4'd11:      fi = 12'd1024;
         4'd12:      fi = 12'd1536;
         4'd13:      fi = 12'd2048;
         default:    fi = 12'd0;
      endcase
      return fi;
   endfunction

   // baud rate adjustment factor Di, zero for reserved codes
   function automatic logic [5:0] di_lookup(input logic [3:0] code);
      logic [5:0] di;
      unique case (code)
         4'd1:    di = 6'd1;
         4'd2:    di = 6'd2;
         4'd3:    di = 6'd4;
         4'd4:    di = 6'd8;
         4'd5:    di = 6'd16;
         4'd6:    di = 6'd32;
         4'd8:    di = 6'd12;
         4'd9:    di = 6'd20;
         default: di = 6'd0;
      endcase
      return di;
   endfunction

endpackage

FILE: design/scatr_decode.sv
// Byte classifier and field decoder with next-state logic of the parser.
module scatr_decode (
   input  scatr_pkg::state_type  state_cur,
   input  logic [7:0]            atr_byte,
   input  logic                  last_byte,
   output scatr_pkg::state_type  state_next,
   output scatr_pkg::result_type result
);
   import scatr_pkg::*;

   state_type  work;
   result_type res;

   always_comb begin
      work = state_cur;
      res = '0;
      res.echo_byte = atr_byte;
      res.protocol_in_effect = state_cur.protocol;

      case (state_cur.phase)
         PH_TS: begin
            res.field_kind = KIND_TS;
            res.decode_kind = DK_CONV;
            if (atr_byte == TS_DIRECT)
               res.part_low = CONV_DIRECT;
            else if (atr_byte == TS_INVERSE)
               res.part_low = CONV_INVERSE;
            else
               res.part_low = CONV_UNDEF;
            work.phase = PH_T0;
         end
         PH_T0: begin
            res.field_kind = KIND_T0;
            res.decode_kind = DK_FORMAT;
            res.part_high = atr_byte[7:4];
            res.part_low = {2'b00, atr_byte[3:0]};
            work.xor_acc = state_cur.xor_acc ^ atr_byte;
            work.pending = atr_byte[7:4];
            work.hist_left = atr_byte[3:0];
            work.phase = settle_phase(work.pending, work.hist_left, work.check_req);
         end
         PH_IF: begin
            work.xor_acc = state_cur.xor_acc ^ atr_byte;
            res.group_index = state_cur.group;
            priority if (state_cur.pending[0]) begin
               res.field_kind = KIND_TA;
               work.pending[0] = 1'b0;
               if (state_cur.group == 4'd1) begin
                  res.decode_kind = DK_RATES;
                  res.part_high = atr_byte[7:4];
                  res.part_low = {2'b00, atr_byte[3:0]};
                  res.clock_rate_factor = fi_lookup(atr_byte[7:4]);
                  res.baud_divisor = di_lookup(atr_byte[3:0]);
               end else if (state_cur.group == 4'd2) begin
                  res.decode_kind = DK_SPECIFIC;
                  res.part_high = atr_byte[7:4];
                  res.part_low = {2'b00, atr_byte[3:0]};
               end else if (state_cur.protocol == PROTO_T1) begin
                  res.decode_kind = DK_IFSC;
               end else begin
                  res.decode_kind = DK_CLASS;
                  res.part_high = {2'b00, atr_byte[7:6]};
                  res.part_low = atr_byte[5:0];
               end
            end else if (state_cur.pending[1]) begin
               res.field_kind = KIND_TB;
               work.pending[1] = 1'b0;
               if (state_cur.group == 4'd1) begin
                  if (atr_byte[4:0] == 5'd0) begin
                     res.decode_kind = DK_NO_VPP;
                  end else begin
                     res.decode_kind = DK_PROG;
                     res.part_high = {1'b0, atr_byte[7:5]};
                     res.part_low = {1'b0, atr_byte[4:0]};
                  end
               end else if (state_cur.group == 4'd2) begin
                  if (atr_byte >= PI2_LOW && atr_byte <= PI2_HIGH)
                     res.decode_kind = DK_PI2;
                  else
                     res.decode_kind = DK_PI2_RFU;
               end else if (state_cur.protocol == PROTO_T1) begin
                  res.decode_kind = DK_BWI_CWI;
                  res.part_high = atr_byte[7:4];
                  res.part_low = {2'b00, atr_byte[3:0]};
               end
            end else if (state_cur.pending[2]) begin
               res.field_kind = KIND_TC;
               work.pending[2] = 1'b0;
               if (state_cur.group == 4'd1) begin
                  res.decode_kind = DK_EGT;
               end else if (state_cur.group == 4'd2) begin
                  res.decode_kind = DK_WI;
               end else if (state_cur.group == 4'd3 && state_cur.protocol == PROTO_T1) begin
                  res.decode_kind = DK_EDC;
                  if (atr_byte == 8'd0)
                     res.part_low = EDC_LRC;
                  else if (atr_byte == 8'd1)
                     res.part_low = EDC_CRC;
                  else
                     res.part_low = EDC_RFU;
               end
            end else begin
               // TD: opens the next group and names its protocol
               res.field_kind = KIND_TD;
               res.decode_kind = DK_TD;
               res.part_high = atr_byte[7:4];
               res.part_low = {2'b00, atr_byte[3:0]};
               work.pending = atr_byte[7:4];
               if (state_cur.group != GROUP_MAX)
                  work.group = state_cur.group + 4'd1;
               work.protocol = atr_byte[3:0];
               if (atr_byte[3:0] != 4'd0)
                  work.check_req = 1'b1;
            end
            work.phase = settle_phase(work.pending, work.hist_left, work.check_req);
         end
         PH_HIST: begin
            res.field_kind = KIND_HIST;
            work.xor_acc = state_cur.xor_acc ^ atr_byte;
            if (state_cur.hist_left != 4'd0)
               work.hist_left = state_cur.hist_left - 4'd1;
            work.phase = settle_phase(work.pending, work.hist_left, work.check_req);
         end
         PH_TCK: begin
            res.field_kind = KIND_TCK;
            work.xor_acc = state_cur.xor_acc ^ atr_byte;
            work.phase = PH_DONE;
         end
         default: begin
            // done and unused codes: the byte is surplus
            res.field_kind = KIND_EXCESS;
            res.decode_kind = DK_EXCESS;
            work.excess = 1'b1;
            work.phase = PH_DONE;
         end
      endcase

      if (last_byte) begin
         priority if (work.phase != PH_DONE)
            res.status = ST_TRUNC;
         else if (work.excess)
            res.status = ST_EXCESS;
         else if (work.check_req && work.xor_acc != 8'd0)
            res.status = ST_BAD_CHECK;
         else
            res.status = ST_OK;
      end
   end

   assign state_next = last_byte ? STATE_RESET : work;
   assign result = res;

endmodule

FILE: design/smartcard_atr_parser.sv
// Top level of the ISO 7816-3 answer-to-reset parser.
// Usage:
//   Feed the answer to reset one byte per req beat (req_atr_byte), with
//   req_last_byte set on its final byte. Every request beat yields exactly
//   one rsp beat: the byte's class (TS, T0, TAi..TDi, historical, TCK,
//   excess), its group and protocol, the decoded fields, Fi/Di for TA1 and,
//   on the final byte, the overall status (ok, bad TCK, truncated, excess).
//   After the final byte the parser rearms and expects a fresh TS.
// Timing:
//   A beat is latched in the request register, decoded against the parse
//   state once the response register is free and written into the
//   response register, which drives rsp_valid. One beat per cycle
//   sustained while rsp_stall stays low.
// Flow control:
//   While rsp_stall holds, the response stays put; one more request beat
//   is buffered, then req_stall rises until the response is taken.
// Reset:
//   Synchronous reset empties both registers and returns the parser to
//   the TS-expected state with a cleared checksum.
module smartcard_atr_parser (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [7:0]  req_atr_byte,
   input  logic        req_last_byte,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [3:0]  rsp_field_kind,
   output logic [3:0]  rsp_group_index,
   output logic [3:0]  rsp_protocol_in_effect,
   output logic [7:0]  rsp_echo_byte,
   output logic [4:0]  rsp_decode_kind,
   output logic [3:0]  rsp_part_high,
   output logic [5:0]  rsp_part_low,
   output logic [11:0] rsp_clock_rate_factor,
   output logic [5:0]  rsp_baud_divisor,
   output logic [2:0]  rsp_status
);
   import scatr_pkg::*;

   `include "smartcard_atr_parser_defines.svh"

   // request register
   logic       in_valid_ff, in_valid_in;
   logic [7:0] in_byte_ff, in_byte_in;
   logic       in_last_ff, in_last_in;

   // parse state
   state_type  state_ff, state_in;
   state_type  state_next;

   // response register
   logic       out_valid_ff, out_valid_in;
   result_type result_ff, result_in;
   result_type result_next;

   logic in_take;
   logic out_free;
   logic advance;

   // the response slot frees when empty or when its beat leaves now
   assign out_free  = !out_valid_ff || !rsp_stall;
   assign advance   = in_valid_ff && out_free;
   assign req_stall = in_valid_ff && !out_free;
   assign in_take   = req_valid && !req_stall;

   scatr_decode u_decode (
      .state_cur  (state_ff),
      .atr_byte   (in_byte_ff),
      .last_byte  (in_last_ff),
      .state_next (state_next),
      .result     (result_next)
   );

   always_comb begin
      // hold the request beat until the decoder consumes it
      if (in_take)
         in_valid_in = 1'b1;
      else if (advance)
         in_valid_in = 1'b0;
      else
         in_valid_in = in_valid_ff;
      in_byte_in = in_take ? req_atr_byte : in_byte_ff;
      in_last_in = in_take ? req_last_byte : in_last_ff;

      // advance the parse state once per decoded byte
      state_in = advance ? state_next : state_ff;

      // load a new response, drop a taken one, else hold
      if (advance)
         out_valid_in = 1'b1;
      else if (out_valid_ff && !rsp_stall)
         out_valid_in = 1'b0;
      else
         out_valid_in = out_valid_ff;
      result_in = advance ? result_next : result_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
         state_ff     <= STATE_RESET;
      end else begin
         in_valid_ff  <= in_valid_in;
         out_valid_ff <= out_valid_in;
         state_ff     <= state_in;
      end
   end

   always_ff @(posedge clock) begin
      in_byte_ff <= in_byte_in;
      in_last_ff <= in_last_in;
      result_ff  <= result_in;
   end

   assign rsp_valid              = out_valid_ff;
   assign rsp_field_kind         = result_ff.field_kind;
   assign rsp_group_index        = result_ff.group_index;
   assign rsp_protocol_in_effect = result_ff.protocol_in_effect;
   assign rsp_echo_byte          = result_ff.echo_byte;
   assign rsp_decode_kind        = result_ff.decode_kind;
   assign rsp_part_high          = result_ff.part_high;
   assign rsp_part_low           = result_ff.part_low;
   assign rsp_clock_rate_factor  = result_ff.clock_rate_factor;
   assign rsp_baud_divisor       = result_ff.baud_divisor;
   assign rsp_status             = result_ff.status;

   // a decoded final byte rearms the parser with a cleared checksum
   `SCATR_ASSERT(a_rearm_after_last, clock, reset, (advance && in_last_ff) |=> (state_ff == STATE_RESET))
   // back-pressure only while both registers are occupied
   `SCATR_ASSERT_ALWAYS(a_stall_when_full, clock, req_stall |-> (in_valid_ff && out_valid_ff))
   // surplus bytes only ever follow a completed answer
   `SCATR_ASSERT(a_excess_after_done, clock, reset, state_ff.excess |-> (state_ff.phase == PH_DONE))
   // interface bytes still owed keep the parser in the interface phase
   `SCATR_ASSERT(a_pending_in_if, clock, reset, (state_ff.pending != 4'd0) |-> (state_ff.phase == PH_IF))

endmodule
